[hdl/aw2x_pkg.sv]
package aw2x_pkg;

    // Field and port widths.
    localparam int PIX_W      = 32;
    localparam int OFF_W      = 28;
    localparam int STRIDE_W   = 16;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Register reset values.
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd2560;
    localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 11'd640;
    localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 11'd400;

    // Destination formats.
    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_RGBA8888 = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_FORMAT = 2'd0,
        REG_ROW_STRIDE = 2'd1,
        REG_SRC_WIDTH  = 2'd2,
        REG_SRC_HEIGHT = 2'd3
    } reg_idx_t;

    // Color masks.
    localparam logic [PIX_W-1:0] MASK_R565  = 32'h0000_f800;
    localparam logic [PIX_W-1:0] MASK_G565  = 32'h0000_07e0;
    localparam logic [PIX_W-1:0] MASK_B565  = 32'h0000_001f;
    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hff00_0000;
    localparam logic [PIX_W-1:0] MASK_BYTE2 = 32'h00ff_0000;
    localparam logic [PIX_W-1:0] MASK_BYTE1 = 32'h0000_ff00;
    localparam logic [PIX_W-1:0] MASK_BYTE0 = 32'h0000_00ff;

    // Live configuration seen by the datapath.
    typedef struct packed {
        logic                out_format;
        logic [STRIDE_W-1:0] row_stride;
        logic [SIZE_W-1:0]   src_width;
        logic [SIZE_W-1:0]   src_height;
    } cfg_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic [OFF_W-1:0] row_base;
        logic [OFF_W-1:0] col_off;
        logic             frame_done;
    } item_t;

    // Top bits of R, G and B packed as 5/6/5.
    function automatic logic [PIX_W-1:0] to_565(input logic [PIX_W-1:0] p);
        return ((p >> 8) & MASK_R565) | ((p >> 5) & MASK_G565) | ((p >> 3) & MASK_B565);
    endfunction

    // Swap R and B and force alpha to opaque.
    function automatic logic [PIX_W-1:0] to_rgba(input logic [PIX_W-1:0] p);
        return ALPHA_OPAQUE | ((p & MASK_BYTE2) >> 16) | (p & MASK_BYTE1)
             | ((p & MASK_BYTE0) << 16);
    endfunction

endpackage

[hdl/aw2x_if.sv]
// Source pixel channel.
interface aw2x_pix_if;
    logic                          valid;
    logic                          ready;
    logic [aw2x_pkg::PIX_W-1:0]    src_pixel;
    logic                          frame_start;

    modport source (output valid, output src_pixel, output frame_start, input ready);
    modport sink   (input valid, input src_pixel, input frame_start, output ready);
endinterface

// Converted pixel and destination offsets.
interface aw2x_res_if;
    logic                          valid;
    logic                          ready;
    logic [aw2x_pkg::PIX_W-1:0]    out_color;
    logic [aw2x_pkg::OFF_W-1:0]    top_offset;
    logic [aw2x_pkg::OFF_W-1:0]    bottom_offset;
    logic                          frame_done;

    modport source (output valid, output out_color, output top_offset,
                    output bottom_offset, output frame_done, input ready);
    modport sink   (input valid, input out_color, input top_offset,
                    input bottom_offset, input frame_done, output ready);
endinterface

// Configuration write channel.
interface aw2x_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aw2x_pkg::CFG_IDX_W-1:0]  index;
    logic [aw2x_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/argb_to_rgb565_rgba_upscale2x_core.sv]
// ARGB8888 pixel converter with 2x nearest-neighbor destination addressing.
// Channels: pix carries one source pixel per item in raster order, with
// frame_start marking the first pixel of a frame. res returns one item per
// pixel: the converted color (RGB565 or RGBA8888) and the byte offsets of
// the pixel pair in destination rows 2y and 2y+1. cfg writes the format,
// row stride and source size; it is always ready, and the user is to use it
// only while idle, which the block itself does not enforce. An accepted pixel
// goes into the queue, then into the result register. Throughput is one
// item per clock while res is ready; a two-entry queue between the front's
// raster counters and the back's offset adders keeps pix ready while the
// result register waits. When the receiver stalls, the result holds, the
// queue fills, and pix.ready drops once two items are waiting behind it.
// Reset clears the raster position and all in-flight items and returns the
// registers to RGB565, stride 2560 and a 640 by 400 frame.
module argb_to_rgb565_rgba_upscale2x_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    aw2x_pix_if.sink    pix,
    aw2x_res_if.source  res,
    aw2x_cfg_if.sink    cfg
);

    aw2x_pkg::cfg_t  cfg_reg, cfg_next;
    aw2x_pkg::item_t push_item;
    aw2x_pkg::item_t pop_item;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    assign cfg.ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (aw2x_pkg::reg_idx_t'(cfg.index))
                aw2x_pkg::REG_OUT_FORMAT: cfg_next.out_format = cfg.data[0];
                aw2x_pkg::REG_ROW_STRIDE: cfg_next.row_stride = cfg.data;
                aw2x_pkg::REG_SRC_WIDTH:
                    cfg_next.src_width = cfg.data[aw2x_pkg::SIZE_W-1:0];
                aw2x_pkg::REG_SRC_HEIGHT:
                    cfg_next.src_height = cfg.data[aw2x_pkg::SIZE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_format <= aw2x_pkg::FMT_RGB565;
            cfg_reg.row_stride <= aw2x_pkg::STRIDE_RESET;
            cfg_reg.src_width  <= aw2x_pkg::WIDTH_RESET;
            cfg_reg.src_height <= aw2x_pkg::HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: raster tracking and color conversion.
    aw2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    // Decoupling queue.
    aw2x_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // Back: offset arithmetic and result register.
    aw2x_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .res     (res)
    );

endmodule

[hdl/aw2x_front.sv]
module aw2x_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    aw2x_pix_if.sink            pix,
    input  aw2x_pkg::cfg_t      cfg,
    input  logic                q_full,
    output logic                q_push,
    output aw2x_pkg::item_t     q_item
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CNT_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W   = (CNT_W + 1 > aw2x_pkg::SIZE_W) ? CNT_W + 1 : aw2x_pkg::SIZE_W;
    localparam int OFF_W   = aw2x_pkg::OFF_W;

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [OFF_W-1:0] base_reg, base_next, base_cur;
    logic [CMP_W-1:0] width_lim, height_lim;
    logic [OFF_W-1:0] col_ext;
    logic             accept;
    logic             last_col;
    logic             last_row;

    assign pix.ready = !q_full;
    assign accept    = pix.valid && pix.ready;
    assign q_push    = accept;

    // Clamp the configured frame size to the supported range.
    always_comb
    begin
        if (cfg.src_width == '0)
            width_lim = CMP_W'(1);
        else if (CMP_W'(cfg.src_width) > CMP_W'(MAX_WIDTH))
            width_lim = CMP_W'(MAX_WIDTH);
        else
            width_lim = CMP_W'(cfg.src_width);

        if (cfg.src_height == '0)
            height_lim = CMP_W'(1);
        else if (CMP_W'(cfg.src_height) > CMP_W'(MAX_HEIGHT))
            height_lim = CMP_W'(MAX_HEIGHT);
        else
            height_lim = CMP_W'(cfg.src_height);
    end

    // A frame start puts this item at the first pixel.
    assign col_cur  = pix.frame_start ? '0 : col_reg;
    assign row_cur  = pix.frame_start ? '0 : row_reg;
    assign base_cur = pix.frame_start ? '0 : base_reg;

    assign last_col = (CMP_W'(col_cur) + CMP_W'(1)) >= width_lim;
    assign last_row = (CMP_W'(row_cur) + CMP_W'(1)) >= height_lim;

    // Classify the item: converted color, row base and column byte offset.
    assign col_ext = OFF_W'(col_cur);

    always_comb
    begin
        q_item.row_base   = base_cur;
        q_item.frame_done = last_col && last_row;
        if (cfg.out_format == aw2x_pkg::FMT_RGBA8888)
        begin
            q_item.color   = aw2x_pkg::to_rgba(pix.src_pixel);
            q_item.col_off = col_ext << 3;
        end
        else
        begin
            q_item.color   = aw2x_pkg::to_565(pix.src_pixel);
            q_item.col_off = col_ext << 2;
        end
    end

    // Raster position for the next item.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next  = row_cur + ROW_W'(1);
                    base_next = base_cur + (OFF_W'(cfg.row_stride) << 1);
                end
            end
            else
            begin
                col_next  = col_cur + COL_W'(1);
                row_next  = row_cur;
                base_next = base_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

[hdl/aw2x_queue.sv]
module aw2x_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aw2x_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output aw2x_pkg::item_t pop_item,
    output logic            empty
);

    localparam int DEPTH = aw2x_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    aw2x_pkg::item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == (PTR_W + 1)'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (PTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[hdl/aw2x_back.sv]
module aw2x_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  aw2x_pkg::item_t q_item,
    output logic            q_pop,
    input  aw2x_pkg::cfg_t  cfg,
    aw2x_res_if.source      res
);

    localparam int OFF_W = aw2x_pkg::OFF_W;

    logic                         valid_reg, valid_next;
    logic [aw2x_pkg::PIX_W-1:0]   color_reg;
    logic [OFF_W-1:0]             top_reg;
    logic [OFF_W-1:0]             bottom_reg;
    logic                         done_reg;
    logic [OFF_W-1:0]             top_sum;
    logic [OFF_W-1:0]             bottom_sum;

    // Take the next item whenever the output register is free or draining.
    assign q_pop = !q_empty && (!valid_reg || res.ready);

    // Destination offsets for rows 2y and 2y+1, wrapping at the offset width.
    assign top_sum    = q_item.row_base + q_item.col_off;
    assign bottom_sum = q_item.row_base + q_item.col_off + OFF_W'(cfg.row_stride);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            color_reg  <= q_item.color;
            top_reg    <= top_sum;
            bottom_reg <= bottom_sum;
            done_reg   <= q_item.frame_done;
        end
    end

    assign res.valid         = valid_reg;
    assign res.out_color     = color_reg;
    assign res.top_offset    = top_reg;
    assign res.bottom_offset = bottom_reg;
    assign res.frame_done    = done_reg;

endmodule

[hdl/aw2x_checker.sv]
module aw2x_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_out_color,
    input logic [27:0] res_top_offset,
    input logic        res_frame_done,
    input logic        cfg_ready
);

    logic [2:0] inflight_reg, inflight_next;
    logic       pix_acc;
    logic       res_acc;

    assign pix_acc = pix_valid && pix_ready;
    assign res_acc = res_valid && res_ready;

    // Items accepted on pix whose results have not yet been taken.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (pix_acc && !res_acc)
            inflight_next = inflight_reg + 3'd1;
        else if (res_acc && !pix_acc)
            inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // A result never appears without an item behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> inflight_reg != 3'd0)
        else $error("result shown with no item in flight");

    // Storage holds at most the queue plus the output register.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd3)
        else $error("more items in flight than storage");

    // Input backpressure only when the block is full.
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> inflight_reg >= 3'd3)
        else $error("pixel input stalled with room left");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_color)
            && $stable(res_top_offset) && $stable(res_frame_done))
        else $error("stalled result changed");

    // Configuration is always accepted.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind argb_to_rgb565_rgba_upscale2x_core aw2x_checker u_aw2x_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_out_color  (res.out_color),
    .res_top_offset (res.top_offset),
    .res_frame_done (res.frame_done),
    .cfg_ready      (cfg.ready)
);
